// File: rtl/raf_pkg.sv
// ----------------------------------------------------------------------------
// Running average filter package
// Shared constants, control types and the window saturation function.
// ----------------------------------------------------------------------------
package raf_pkg;

  localparam int MAX_WINDOW = 32;
  localparam int DATA_W     = 32;
  localparam int CFG_W      = 6;
  localparam int SLOT_W     = $clog2(MAX_WINDOW);
  localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W      = DATA_W + SLOT_W;
  localparam int REM_W      = CNT_W + 1;
  localparam int STEP_W     = $clog2(SUM_W + 1);

  localparam logic [CFG_W-1:0] DEFAULT_WINDOW = CFG_W'(20);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SUB  = 6'b000010,
    S_ADD  = 6'b000100,
    S_LOAD = 6'b001000,
    S_DIV  = 6'b010000,
    S_HOLD = 6'b100000
  } state_t;

  typedef struct packed {
    logic start;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic [CNT_W-1:0] effective_window(input logic [CFG_W-1:0] w);
    logic [CNT_W-1:0] r;
    if (w == '0) begin
      r = CNT_W'(1);
    end else if (int'(w) > MAX_WINDOW) begin
      r = CNT_W'(MAX_WINDOW);
    end else begin
      r = CNT_W'(w);
    end
    return r;
  endfunction

endpackage

// File: rtl/raf_store.sv
// ----------------------------------------------------------------------------
// Running average sample store
// Circular sample memory with a registered read port and per-entry valid
// bits, so that a cleared entry reads as zero.
// ----------------------------------------------------------------------------
module raf_store (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                clear,
  input  logic                                rd_en,
  input  logic [raf_pkg::SLOT_W-1:0]          rd_addr,
  input  logic                                wr_en,
  input  logic [raf_pkg::SLOT_W-1:0]          wr_addr,
  input  logic signed [raf_pkg::DATA_W-1:0]   wr_data,
  output logic signed [raf_pkg::DATA_W-1:0]   rd_data
);

  logic signed [raf_pkg::DATA_W-1:0] mem [raf_pkg::MAX_WINDOW];
  logic [raf_pkg::MAX_WINDOW-1:0]    valid;
  logic signed [raf_pkg::DATA_W-1:0] rd_word;
  logic                              rd_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_word <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else if (rd_en) begin
      rd_valid <= valid[rd_addr];
    end
  end

  assign rd_data = rd_valid ? rd_word : '0;

endmodule

// File: rtl/raf_divider.sv
// ----------------------------------------------------------------------------
// Running average serial divider
// Radix-2 restoring divider that shifts the sum magnitude through one bit
// per cycle and returns the quotient truncated toward zero.
// ----------------------------------------------------------------------------
module raf_divider (
  input  logic                               clk,
  input  logic                               rst,
  input  raf_pkg::div_req_t                  req,
  input  logic signed [raf_pkg::SUM_W-1:0]   dividend,
  input  logic [raf_pkg::CNT_W-1:0]          divisor,
  output raf_pkg::div_stat_t                 stat,
  output logic signed [raf_pkg::DATA_W-1:0]  quotient
);

  logic [raf_pkg::SUM_W-1:0]  acc;
  logic [raf_pkg::REM_W-1:0]  rem;
  logic [raf_pkg::CNT_W-1:0]  dvs;
  logic                       neg;
  logic [raf_pkg::STEP_W-1:0] step;
  logic                       busy;
  logic                       done;

  logic [raf_pkg::SUM_W-1:0]  dvd_u;
  logic [raf_pkg::SUM_W-1:0]  mag;
  logic [raf_pkg::REM_W-1:0]  trial;
  logic [raf_pkg::REM_W-1:0]  dvs_ext;
  logic                       fits;

  assign dvd_u   = dividend;
  assign mag     = dvd_u[raf_pkg::SUM_W-1] ? raf_pkg::SUM_W'(~dvd_u + 1'b1) : dvd_u;
  assign trial   = {rem[raf_pkg::REM_W-2:0], acc[raf_pkg::SUM_W-1]};
  assign dvs_ext = raf_pkg::REM_W'(dvs);
  assign fits    = trial >= dvs_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= raf_pkg::STEP_W'(raf_pkg::SUM_W);
      end else if (busy) begin
        step <= step - raf_pkg::STEP_W'(1);
        if (step == raf_pkg::STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      acc <= mag;
      rem <= '0;
      dvs <= divisor;
      neg <= dvd_u[raf_pkg::SUM_W-1];
    end else if (busy) begin
      rem <= fits ? (trial - dvs_ext) : trial;
      acc <= {acc[raf_pkg::SUM_W-2:0], fits};
    end
  end

  assign quotient  = neg ? -acc[raf_pkg::DATA_W-1:0] : acc[raf_pkg::DATA_W-1:0];
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// File: rtl/running_average_filter_top.sv
// ----------------------------------------------------------------------------
// Running average filter
// Moving average over the most recent window_length signed samples.
//
// The input channel takes one 32-bit sample word per handshake (valid high,
// stall low). The block takes one sample at a time and stalls the input
// while that sample is being worked on. Each sample yields one average word
// on the output channel: the sum of the held samples divided by their count,
// truncated toward zero. Each accepted sample passes through the subtract,
// add and load states, the 37-step bit-serial divider and the output
// register before its average is presented as valid on the output channel.
// The average sits in an output register, so a new sample is taken while
// the receiver stalls; if the next average is ready before the previous one
// is taken, the block holds it and keeps the input stalled.
// Reset sets the window to 20 and clears the store, sum, slot and count.
// Writing window_length does the same with the new window; a window of zero
// acts as one and windows above 32 saturate. Write it only while idle.
// ----------------------------------------------------------------------------
module running_average_filter_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               window_length_we,
  input  logic [raf_pkg::CFG_W-1:0]          window_length,
  input  logic signed [raf_pkg::DATA_W-1:0]  sample,
  input  logic                               sample_valid,
  output logic                               sample_stall,
  output logic signed [raf_pkg::DATA_W-1:0]  average,
  output logic                               average_valid,
  input  logic                               average_stall
);

  raf_pkg::state_t                   state;
  raf_pkg::state_t                   state_next;
  logic [raf_pkg::CFG_W-1:0]         win_cfg;
  logic [raf_pkg::CNT_W-1:0]         win;
  logic signed [raf_pkg::DATA_W-1:0] sample_q;
  logic [raf_pkg::SLOT_W-1:0]        slot;
  logic [raf_pkg::SLOT_W-1:0]        slot_use;
  logic [raf_pkg::CNT_W-1:0]         slot_inc;
  logic [raf_pkg::CNT_W-1:0]         fill;
  logic signed [raf_pkg::SUM_W-1:0]  sum;
  logic signed [raf_pkg::DATA_W-1:0] old_word;
  logic signed [raf_pkg::DATA_W-1:0] div_quot;
  raf_pkg::div_req_t                 div_req;
  raf_pkg::div_stat_t                div_stat;
  logic                              accept;
  logic                              out_free;
  logic                              out_load;

  assign win          = raf_pkg::effective_window(win_cfg);
  assign slot_use     = (raf_pkg::CNT_W'(slot) >= win) ? '0 : slot;
  assign slot_inc     = raf_pkg::CNT_W'(slot) + raf_pkg::CNT_W'(1);
  assign sample_stall = state != raf_pkg::S_IDLE;
  assign accept       = sample_valid && (state == raf_pkg::S_IDLE);
  assign out_free     = !average_valid || !average_stall;
  assign out_load     = ((state == raf_pkg::S_DIV && div_stat.done) ||
                         state == raf_pkg::S_HOLD) && out_free;
  assign div_req.start = state == raf_pkg::S_LOAD;

  raf_store u_store (
    .clk     (clk),
    .rst     (rst),
    .clear   (window_length_we),
    .rd_en   (accept),
    .rd_addr (slot_use),
    .wr_en   (state == raf_pkg::S_SUB),
    .wr_addr (slot),
    .wr_data (sample_q),
    .rd_data (old_word)
  );

  raf_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .dividend (sum),
    .divisor  (fill),
    .stat     (div_stat),
    .quotient (div_quot)
  );

  always_comb begin
    state_next = state;
    case (state)
      raf_pkg::S_IDLE: begin
        if (accept) begin
          state_next = raf_pkg::S_SUB;
        end
      end
      raf_pkg::S_SUB:  state_next = raf_pkg::S_ADD;
      raf_pkg::S_ADD:  state_next = raf_pkg::S_LOAD;
      raf_pkg::S_LOAD: state_next = raf_pkg::S_DIV;
      raf_pkg::S_DIV: begin
        if (div_stat.done) begin
          state_next = out_free ? raf_pkg::S_IDLE : raf_pkg::S_HOLD;
        end
      end
      raf_pkg::S_HOLD: begin
        if (out_free) begin
          state_next = raf_pkg::S_IDLE;
        end
      end
      default: state_next = raf_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= raf_pkg::S_IDLE;
      win_cfg <= raf_pkg::DEFAULT_WINDOW;
      slot    <= '0;
      fill    <= '0;
      sum     <= '0;
    end else begin
      state <= state_next;
      if (window_length_we) begin
        win_cfg <= window_length;
        slot    <= '0;
        fill    <= '0;
        sum     <= '0;
      end else begin
        case (state)
          raf_pkg::S_IDLE: begin
            if (accept) begin
              slot <= slot_use;
            end
          end
          raf_pkg::S_SUB: begin
            sum <= sum - raf_pkg::SUM_W'(old_word);
          end
          raf_pkg::S_ADD: begin
            sum  <= sum + raf_pkg::SUM_W'(sample_q);
            slot <= (slot_inc >= win) ? '0 : raf_pkg::SLOT_W'(slot_inc);
            if (fill < win) begin
              fill <= fill + raf_pkg::CNT_W'(1);
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample_q <= sample;
    end
    if (out_load) begin
      average <= div_quot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      average_valid <= 1'b0;
    end else if (out_load) begin
      average_valid <= 1'b1;
    end else if (!average_stall) begin
      average_valid <= 1'b0;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= win) else $error("fill count above window");

  a_slot_bound: assert property (@(posedge clk) disable iff (rst)
    raf_pkg::CNT_W'(slot) < win) else $error("write slot outside window");

  a_done_state: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> state == raf_pkg::S_DIV) else $error("divider done out of turn");

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_stat.busy) else $error("divider started while busy");

endmodule

// File: sim/average_checker.sv
// ----------------------------------------------------------------------------
// Running average checker
// Watches the sample, average and window_length ports of the filter. It keeps
// its own copy of the sample window and predicts each average word. It then
// compares every accepted average word with the oldest prediction still
// waiting. The top reads the mismatch count and the number of words still
// expected.
// ----------------------------------------------------------------------------
module average_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               window_length_we,
  input  logic [raf_pkg::CFG_W-1:0]          window_length,
  input  logic signed [raf_pkg::DATA_W-1:0]  sample,
  input  logic                               sample_valid,
  input  logic                               sample_stall,
  input  logic signed [raf_pkg::DATA_W-1:0]  average,
  input  logic                               average_valid,
  input  logic                               average_stall,
  output int                                 mismatches,
  output int                                 outstanding
);

  logic signed [raf_pkg::DATA_W-1:0] held_samples [raf_pkg::MAX_WINDOW];
  logic signed [raf_pkg::SUM_W-1:0]  window_total;
  int unsigned                       oldest_slot;
  int unsigned                       held_count;
  logic [raf_pkg::CFG_W-1:0]         window_setting;
  logic signed [raf_pkg::DATA_W-1:0] expected_averages [$];
  logic signed [raf_pkg::DATA_W-1:0] wanted;

  function automatic int unsigned window_span(logic [raf_pkg::CFG_W-1:0] w);
    int unsigned span;
    span = w;
    if (span == 0) begin
      span = 1;
    end else if (span > raf_pkg::MAX_WINDOW) begin
      span = raf_pkg::MAX_WINDOW;
    end
    return span;
  endfunction

  task automatic clear_window();
    foreach (held_samples[i]) begin
      held_samples[i] = '0;
    end
    window_total = '0;
    oldest_slot = 0;
    held_count = 0;
  endtask

  function automatic logic signed [raf_pkg::DATA_W-1:0] predict_average(
    logic signed [raf_pkg::DATA_W-1:0] fresh
  );
    int unsigned span;
    longint      quotient;
    span = window_span(window_setting);
    if (oldest_slot >= span) begin
      oldest_slot = 0;
    end
    window_total = window_total - held_samples[oldest_slot] + fresh;
    held_samples[oldest_slot] = fresh;
    oldest_slot++;
    if (oldest_slot >= span) begin
      oldest_slot = 0;
    end
    if (held_count < span) begin
      held_count++;
    end
    quotient = longint'(window_total) / longint'(held_count);
    return quotient[raf_pkg::DATA_W-1:0];
  endfunction

  initial begin
    mismatches = 0;
    outstanding = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      window_setting = raf_pkg::DEFAULT_WINDOW;
      clear_window();
      expected_averages.delete();
    end else begin
      if (window_length_we) begin
        window_setting = window_length;
        clear_window();
      end
      if (sample_valid && !sample_stall) begin
        expected_averages.push_back(predict_average(sample));
      end
      if (average_valid && !average_stall) begin
        if (expected_averages.size() == 0) begin
          $display("%0t: average word %0d arrived with no word expected", $time, average);
          mismatches++;
        end else begin
          wanted = expected_averages.pop_front();
          if (average !== wanted) begin
            $display("%0t: average mismatch, expected %0d, got %0d", $time, wanted, average);
            mismatches++;
          end
        end
      end
    end
    outstanding = expected_averages.size();
  end

endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// Running average filter testbench
// Drives sample words with random gaps and random stalls on the average side,
// rewrites the window length between phases (zero, one, full, saturating and
// random windows), holds the output off once long enough to back up the
// input, and reports the verdict from the checker's counts.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int DRAIN_CYCLES  = 60;
  localparam int LONG_HOLD     = 400;
  localparam int RANDOM_ITEMS  = 750;
  localparam int QUIET_ITEMS   = 100;
  localparam logic signed [raf_pkg::DATA_W-1:0] SAMPLE_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [raf_pkg::DATA_W-1:0] SAMPLE_MIN = 32'sh8000_0000;

  typedef enum int {MIX_ANY, MIX_HIGH, MIX_LOW} sample_mix_t;

  logic                               clk = 1'b0;
  logic                               rst;
  logic                               window_length_we;
  logic [raf_pkg::CFG_W-1:0]          window_length;
  logic signed [raf_pkg::DATA_W-1:0]  sample;
  logic                               sample_valid;
  logic                               sample_stall;
  logic signed [raf_pkg::DATA_W-1:0]  average;
  logic                               average_valid;
  logic                               average_stall;
  int                                 mismatches;
  int                                 outstanding;

  int          gap_pct = 0;
  int          stall_pct = 0;
  bit          long_hold = 1'b0;
  sample_mix_t mix = MIX_ANY;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  running_average_filter_top dut (
    .clk              (clk),
    .rst              (rst),
    .window_length_we (window_length_we),
    .window_length    (window_length),
    .sample           (sample),
    .sample_valid     (sample_valid),
    .sample_stall     (sample_stall),
    .average          (average),
    .average_valid    (average_valid),
    .average_stall    (average_stall)
  );

  average_checker u_checker (
    .clk              (clk),
    .rst              (rst),
    .window_length_we (window_length_we),
    .window_length    (window_length),
    .sample           (sample),
    .sample_valid     (sample_valid),
    .sample_stall     (sample_stall),
    .average          (average),
    .average_valid    (average_valid),
    .average_stall    (average_stall),
    .mismatches       (mismatches),
    .outstanding      (outstanding)
  );

  function automatic int pick_rate();
    int rate;
    case ($urandom_range(0, 2))
      0: rate = 0;
      1: rate = 15;
      default: rate = 40;
    endcase
    return rate;
  endfunction

  function automatic logic signed [raf_pkg::DATA_W-1:0] pick_sample();
    logic signed [raf_pkg::DATA_W-1:0] v;
    case ($urandom_range(0, 9))
      0: v = SAMPLE_MAX;
      1: v = SAMPLE_MIN;
      2: v = raf_pkg::DATA_W'($urandom_range(0, 6)) - 32'sd3;
      default: v = $urandom;
    endcase
    if (mix == MIX_HIGH && $urandom_range(0, 9) < 7) begin
      v = SAMPLE_MAX - raf_pkg::DATA_W'($urandom_range(0, 15));
    end else if (mix == MIX_LOW && $urandom_range(0, 9) < 7) begin
      v = SAMPLE_MIN + raf_pkg::DATA_W'($urandom_range(0, 15));
    end
    return v;
  endfunction

  task automatic send_sample(logic signed [raf_pkg::DATA_W-1:0] value);
    int n;
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      n = $urandom_range(1, 8);
      @(negedge clk);
      sample_valid <= 1'b0;
      sample <= $urandom;
      repeat (n - 1) @(negedge clk);
    end
    @(negedge clk);
    sample <= value;
    sample_valid <= 1'b1;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    sample_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_window(logic [raf_pkg::CFG_W-1:0] w);
    wait_drained();
    window_length <= w;
    window_length_we <= 1'b1;
    @(negedge clk);
    window_length_we <= 1'b0;
  endtask

  initial begin : drain
    int n;
    average_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        average_stall <= 1'b1;
        repeat (LONG_HOLD - 1) @(negedge clk);
        long_hold = 1'b0;
      end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
        n = $urandom_range(1, 8);
        average_stall <= 1'b1;
        repeat (n - 1) @(negedge clk);
      end else begin
        average_stall <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    logic [raf_pkg::CFG_W-1:0] plan [7];
    int                        total;
    int                        phase;
    int                        count;
    rst = 1'b1;
    window_length_we = 1'b0;
    window_length = '0;
    sample = '0;
    sample_valid = 1'b0;
    plan = '{6'd0, 6'd1, 6'd32, 6'd63, 6'd2, 6'd33, 6'd7};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // The default window first: sums beyond 32 bits, then rounding toward zero.
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MIN);
    send_sample('0);
    send_sample(-32'sd1);
    send_sample(32'sd1);
    send_sample(-32'sd1);
    send_sample(-32'sd2);
    send_sample(-32'sd7);
    send_sample(32'sd7);
    send_sample(32'sh5555_5555);
    send_sample(32'shAAAA_AAAA);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    set_window(6'd0);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MAX);
    send_sample(-32'sd1);
    set_window(6'd63);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);

    total = 0;
    phase = 0;
    while (total < RANDOM_ITEMS) begin
      set_window(phase < 7 ? plan[phase] : raf_pkg::CFG_W'($urandom_range(0, 63)));
      gap_pct = pick_rate();
      stall_pct = pick_rate();
      mix = sample_mix_t'($urandom_range(0, 2));
      if (phase == 2) begin
        long_hold = 1'b1;
      end
      count = $urandom_range(40, 110);
      repeat (count) send_sample(pick_sample());
      total += count;
      phase++;
    end

    set_window(6'd32);
    gap_pct = 0;
    stall_pct = 0;
    mix = MIX_ANY;
    repeat (QUIET_ITEMS) send_sample(pick_sample());

    wait_drained();
    if (mismatches == 0 && outstanding == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// File: filelist.f
rtl/raf_pkg.sv
rtl/raf_store.sv
rtl/raf_divider.sv
rtl/running_average_filter_top.sv
sim/average_checker.sv
sim/tb_top.sv
